// ===== design/atf_pkg.sv =====
// Shared types and constants for the augmented term frequency block.
package atf_pkg;

    localparam int TOKEN_BITS      = 20;
    localparam int COUNT_BITS      = 16;
    localparam int INDEX_BITS      = 10;
    localparam int TF_BITS         = 17;
    localparam int QUOT_BITS       = 16;
    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [TF_BITS-1:0] HALF_ONE = TF_BITS'(32768);

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_READ,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic [1:0]            action;
        logic [TOKEN_BITS-1:0] token_id;
        logic                  is_last;
        logic [INDEX_BITS-1:0] entry_index;
    } t_atf_in;

    typedef struct packed {
        logic                  entry_valid;
        logic [TOKEN_BITS-1:0] term_id;
        logic [COUNT_BITS-1:0] term_count;
        logic [TF_BITS-1:0]    tf_value;
        logic                  overflow;
    } t_atf_out;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } t_div_rsp;

endpackage

// ===== design/atf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module atf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/atf_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(dividend * 2^15 / divisor).
module atf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [atf_pkg::COUNT_BITS-1:0] i_dividend,
    input  logic [atf_pkg::COUNT_BITS-1:0] i_divisor,
    output atf_pkg::t_div_rsp             o_rsp
);
    import atf_pkg::*;

    localparam int STEP_W = $clog2(QUOT_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_BITS - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [COUNT_BITS:0]   r_rem,  n_rem;
    logic [COUNT_BITS-1:0] r_div,  n_div;
    logic [QUOT_BITS-1:0]  r_quot, n_quot;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    // First step has no shift: it yields the integer bit (count == max).
    assign trial = (r_step == '0) ? r_rem : {r_rem[COUNT_BITS-1:0], 1'b0};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = {1'b0, i_dividend};
            n_div  = i_divisor;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = fits ? (trial - {1'b0, r_div}) : trial;
            n_quot = {r_quot[QUOT_BITS-2:0], fits};
            n_step = r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== design/augmented_term_frequency.sv =====
// A plain push or a clear leaves the block idle; a push with is_last passes through ST_CLOSE to store the run.
// Query: the strobe follows the RAM read (ST_READ), 16 divider steps (ST_DIV) and the result
// register, or comes from ST_READ for an index past the end; the next transfer can overlap the strobe.
// Throughput is set by the shared one-bit-per-cycle divider; busy is high while it runs.
// Reset (synchronous, active low) empties the table and clears run state and overflow;
// table contents stay undefined until written. The receiver cannot stall results.
module augmented_term_frequency #(
    parameter int TABLE_DEPTH = atf_pkg::DEF_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  atf_pkg::t_atf_in  i_item,
    output logic              o_strobe,
    output atf_pkg::t_atf_out o_result
);
    import atf_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;
    localparam int WORD_W = TOKEN_BITS + COUNT_BITS;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_entry_cnt, n_entry_cnt;
    logic [COUNT_BITS-1:0] r_max, n_max;
    logic [TOKEN_BITS-1:0] r_run_tok, n_run_tok;
    logic [COUNT_BITS-1:0] r_run_len, n_run_len;
    logic                  r_run_open, n_run_open;
    logic                  r_dropped, n_dropped;
    logic                  r_idx_ok, n_idx_ok;
    logic                  r_strobe, n_strobe;
    t_atf_out              r_out, n_out;
    logic [TOKEN_BITS-1:0] r_term, n_term;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    logic                  close_en;
    logic                  table_full;
    logic                  same_run;
    logic                  wr_en;
    logic                  rd_en;
    logic [WORD_W-1:0]     rd_data;
    logic                  div_start;
    t_div_rsp              div_rsp;

    assign table_full = (r_entry_cnt == CNT_W'(TABLE_DEPTH));
    assign same_run   = r_run_open && (i_item.token_id == r_run_tok);

    // A run closes on a break in the push stream, or in ST_CLOSE, the cycle after an is_last push.
    always_comb begin
        close_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                close_en = start && (i_item.action == ACT_PUSH) && r_run_open && !same_run;
            end
            ST_CLOSE: begin
                close_en = 1'b1;
            end
            default: begin
                close_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_entry_cnt = r_entry_cnt;
        n_max       = r_max;
        n_run_tok   = r_run_tok;
        n_run_len   = r_run_len;
        n_run_open  = r_run_open;
        n_dropped   = r_dropped;
        n_idx_ok    = r_idx_ok;
        n_strobe    = 1'b0;
        n_out       = r_out;
        n_term      = r_term;
        n_cnt       = r_cnt;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        div_start   = 1'b0;

        if (close_en) begin
            if (!table_full) begin
                wr_en       = 1'b1;
                n_entry_cnt = r_entry_cnt + 1'b1;
                if (r_run_len > r_max) begin
                    n_max = r_run_len;
                end
            end else begin
                n_dropped = 1'b1;
            end
            n_run_open = 1'b0;
            n_run_len  = '0;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_item.action)
                        ACT_PUSH: begin
                            if (same_run) begin
                                if (r_run_len != '1) begin
                                    n_run_len = r_run_len + 1'b1;
                                end
                            end else begin
                                n_run_tok  = i_item.token_id;
                                n_run_len  = COUNT_BITS'(1);
                                n_run_open = 1'b1;
                            end
                            if (i_item.is_last) begin
                                n_state = ST_CLOSE;
                            end
                        end
                        ACT_QUERY: begin
                            rd_en    = 1'b1;
                            n_idx_ok = (CMP_W'(i_item.entry_index) < CMP_W'(r_entry_cnt));
                            n_state  = ST_READ;
                        end
                        ACT_CLEAR: begin
                            n_entry_cnt = '0;
                            n_max       = '0;
                            n_run_tok   = '0;
                            n_run_len   = '0;
                            n_run_open  = 1'b0;
                            n_dropped   = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLOSE: begin
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (r_idx_ok) begin
                    n_term    = rd_data[WORD_W-1:COUNT_BITS];
                    n_cnt     = rd_data[COUNT_BITS-1:0];
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_out.entry_valid = 1'b0;
                    n_out.term_id     = '0;
                    n_out.term_count  = '0;
                    n_out.tf_value    = '0;
                    n_out.overflow    = r_dropped;
                    n_strobe          = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_out.entry_valid = 1'b1;
                    n_out.term_id     = r_term;
                    n_out.term_count  = r_cnt;
                    n_out.tf_value    = HALF_ONE + {1'b0, div_rsp.quot};
                    n_out.overflow    = r_dropped;
                    n_strobe          = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry_cnt <= '0;
            r_max       <= '0;
            r_run_tok   <= '0;
            r_run_len   <= '0;
            r_run_open  <= 1'b0;
            r_dropped   <= 1'b0;
            r_idx_ok    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry_cnt <= n_entry_cnt;
            r_max       <= n_max;
            r_run_tok   <= n_run_tok;
            r_run_len   <= n_run_len;
            r_run_open  <= n_run_open;
            r_dropped   <= n_dropped;
            r_idx_ok    <= n_idx_ok;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_term <= n_term;
        r_cnt  <= n_cnt;
    end

    atf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_entry_cnt[ADDR_W-1:0]),
        .i_wdata ({r_run_tok, r_run_len}),
        .i_re    (rd_en),
        .i_raddr (ADDR_W'(i_item.entry_index)),
        .o_rdata (rd_data)
    );

    atf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_data[COUNT_BITS-1:0]),
        .i_divisor  (r_max),
        .o_rsp      (div_rsp)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("entry count past table depth");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_state) == ST_READ) || ($past(r_state) == ST_DIV))
        else $error("result strobe outside a query");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.entry_valid) |->
        (o_result.tf_value == '0) && (o_result.term_id == '0) && (o_result.term_count == '0))
        else $error("invalid entry returned nonzero payload");

    a_tf_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.entry_valid) |-> (o_result.tf_value >= HALF_ONE))
        else $error("tf value below one half");

    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_open |-> (r_run_len == '0))
        else $error("closed run holds a length");
`endif

endmodule

// ===== sim/augmented_term_frequency_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the augmented term frequency table block.
module augmented_term_frequency_tb;
    import atf_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [TOKEN_BITS-1:0] TOKEN_TOP = '1;
    localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 425;
    localparam int TAIL_CYCLES = 30;
    localparam int DRAIN_LIMIT = 2000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_atf_in  i_item = '0;
    logic     o_strobe;
    t_atf_out o_result;

    augmented_term_frequency dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table and run state
    logic [TOKEN_BITS-1:0] shadow_terms [DEPTH];
    logic [COUNT_BITS-1:0] shadow_counts [DEPTH];
    int unsigned           stored_terms;
    int unsigned           peak_count;
    logic [TOKEN_BITS-1:0] run_tok;
    int unsigned           run_len;
    bit                    run_active;
    bit                    table_dropped;

    t_atf_out    pending_lookups [$];
    int          idle_pct;
    int unsigned sent_items;
    int unsigned lookups_checked;
    int unsigned valid_hits;
    int unsigned overflow_hits;
    int unsigned err_cnt;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    function automatic void close_run();
        if (!run_active) begin
            return;
        end
        if (stored_terms < DEPTH) begin
            shadow_terms[stored_terms]  = run_tok;
            shadow_counts[stored_terms] = COUNT_BITS'(run_len);
            stored_terms++;
            if (run_len > peak_count) begin
                peak_count = run_len;
            end
        end else begin
            table_dropped = 1'b1;
        end
        run_active = 1'b0;
        run_len    = 0;
    endfunction

    function automatic void reset_table();
        stored_terms  = 0;
        peak_count    = 0;
        run_tok       = '0;
        run_len       = 0;
        run_active    = 1'b0;
        table_dropped = 1'b0;
    endfunction

    // Update the shadow state for one accepted transfer; queue the lookup answer if any
    function automatic void apply_item(t_atf_in it);
        t_atf_out    want;
        longint unsigned ratio;
        case (it.action)
            ACT_PUSH: begin
                if (run_active && it.token_id == run_tok) begin
                    if (run_len < COUNT_TOP) begin
                        run_len++;
                    end
                end else begin
                    close_run();
                    run_tok    = it.token_id;
                    run_len    = 1;
                    run_active = 1'b1;
                end
                if (it.is_last) begin
                    close_run();
                end
            end
            ACT_CLEAR: reset_table();
            ACT_QUERY: begin
                want = '0;
                if (it.entry_index < stored_terms) begin
                    want.entry_valid = 1'b1;
                    want.term_id     = shadow_terms[it.entry_index];
                    want.term_count  = shadow_counts[it.entry_index];
                    ratio = 0;
                    if (peak_count != 0) begin
                        ratio = (64'd32768 * want.term_count) / peak_count;
                    end
                    want.tf_value = HALF_ONE + TF_BITS'(ratio);
                end
                want.overflow = table_dropped;
                pending_lookups.push_back(want);
            end
            default: ;
        endcase
    endfunction

    function automatic t_atf_in make_item(logic [1:0] act, logic [TOKEN_BITS-1:0] tok,
                                          logic last, logic [INDEX_BITS-1:0] idx);
        t_atf_in it;
        it.action      = act;
        it.token_id    = tok;
        it.is_last     = last;
        it.entry_index = idx;
        return it;
    endfunction

    function automatic t_atf_in random_item();
        t_atf_in it;
        it = t_atf_in'({$urandom, $urandom});
        return it;
    endfunction

    // Issue one command; returns just after the edge at which it transfers
    task automatic send_item(t_atf_in it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= random_item();
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_item(it);
        if (it.action != ACT_UNUSED) begin
            sent_items++;
        end
    endtask

    always @(posedge i_clk) begin
        t_atf_out want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected result, term_id", 32'(o_result.term_id), 32'd0);
            end else begin
                want = pending_lookups.pop_front();
                lookups_checked++;
                if (want.entry_valid) valid_hits++;
                if (want.overflow) overflow_hits++;
                if (o_result.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 32'(o_result.entry_valid),
                                    32'(want.entry_valid));
                if (o_result.term_id !== want.term_id)
                    report_mismatch("term_id", 32'(o_result.term_id), 32'(want.term_id));
                if (o_result.term_count !== want.term_count)
                    report_mismatch("term_count", 32'(o_result.term_count),
                                    32'(want.term_count));
                if (o_result.tf_value !== want.tf_value)
                    report_mismatch("tf_value", 32'(o_result.tf_value), 32'(want.tf_value));
                if (o_result.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_result.overflow), 32'(want.overflow));
            end
        end
    end

    task automatic test_directed();
        idle_pct = 0;
        send_item(make_item(ACT_PUSH,  '0, 1'b0, '1));
        send_item(make_item(ACT_QUERY, '0, 1'b1, '0));        // open run not visible yet
        send_item(make_item(ACT_PUSH,  '0, 1'b0, '0));
        send_item(make_item(ACT_PUSH,  '0, 1'b0, '0));
        send_item(make_item(ACT_PUSH,  TOKEN_TOP, 1'b0, '0));
        send_item(make_item(ACT_PUSH,  20'h00010, 1'b1, '0)); // unsorted break plus last
        send_item(make_item(ACT_QUERY, '1, 1'b0, 10'd0));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd1));
        send_item(make_item(ACT_QUERY, '0, 1'b1, 10'd2));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd3));     // one past the end
        send_item(make_item(ACT_QUERY, '0, 1'b0, '1));
        send_item(make_item(ACT_UNUSED, TOKEN_TOP, 1'b1, 10'd0));
        send_item(make_item(ACT_PUSH,  20'h12345, 1'b1, '0));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd3));
        send_item(make_item(ACT_PUSH,  20'h00007, 1'b0, '0));
        send_item(make_item(ACT_PUSH,  20'h00007, 1'b1, '0));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd4));
        send_item(make_item(ACT_CLEAR, TOKEN_TOP, 1'b1, '1));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd0));
        send_item(make_item(ACT_PUSH,  20'h00009, 1'b0, '0));
        send_item(make_item(ACT_CLEAR, '0, 1'b0, '0));        // drops the open run
        send_item(make_item(ACT_PUSH,  20'h00009, 1'b1, '0));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd0));
        send_item(make_item(ACT_QUERY, '0, 1'b0, 10'd1));
    endtask

    // Documents of mostly sorted runs with random content, queries, clears and some noise
    task automatic test_random_mix();
        int                    phase_pct [4] = '{0, 45, 0, 19};
        int unsigned           base;
        int                    pick;
        int                    n_runs;
        int                    len;
        bit                    close_doc;
        logic [TOKEN_BITS-1:0] tok;
        logic [INDEX_BITS-1:0] idx;
        t_atf_in               it;
        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS) begin
            idle_pct = phase_pct[((sent_items - base) * 4 / RANDOM_ITEMS) % 4];
            pick = $urandom_range(99);
            if (pick < 8) begin
                it = random_item();
                it.action = ACT_CLEAR;
                send_item(it);
            end else if (pick < 11) begin
                it = random_item();
                it.action = ACT_UNUSED;
                send_item(it);
            end else if (pick < 55) begin
                n_runs    = $urandom_range(1, 8);
                close_doc = $urandom_range(9) != 0;
                tok       = TOKEN_BITS'($urandom);
                for (int r = 0; r < n_runs; r++) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        it = random_item();
                        it.action   = ACT_PUSH;
                        it.token_id = tok;
                        it.is_last  = close_doc && r == n_runs - 1 && k == len - 1;
                        send_item(it);
                    end
                    if ($urandom_range(19) == 0) begin
                        tok = TOKEN_BITS'($urandom);        // out-of-order id
                    end else begin
                        tok = tok + TOKEN_BITS'($urandom_range(1, 4096));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(3) == 0) begin
                        idx = INDEX_BITS'($urandom);
                    end else begin
                        idx = INDEX_BITS'($urandom_range(0, (stored_terms < DEPTH - 1) ?
                                                            stored_terms + 1 : DEPTH - 1));
                    end
                    it = random_item();
                    it.action      = ACT_QUERY;
                    it.entry_index = idx;
                    send_item(it);
                end
            end
        end
    endtask

    initial begin
        int waited;
        reset_table();
        sent_items      = 0;
        lookups_checked = 0;
        valid_hits      = 0;
        overflow_hits   = 0;
        err_cnt         = 0;
        idle_pct        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();

        start <= 1'b0;
        waited = 0;
        while (pending_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_lookups.size() != 0) begin
            report_mismatch("results never returned", 32'(pending_lookups.size()), 32'd0);
        end

        $display("Run covered %0d transfers and %0d checked lookups (%0d valid, %0d with overflow)",
                 sent_items, lookups_checked, valid_hits, overflow_hits);
        $display("including run breaks, final runs, past-the-end lookups, idle gaps and clears");
        if (err_cnt == 0) begin
            $display("augmented_term_frequency: match");
        end else begin
            $display("augmented_term_frequency: mismatch");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timeout: simulation did not finish");
        $display("augmented_term_frequency: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/atf_pkg.sv
design/atf_ram.sv
design/atf_div.sv
design/augmented_term_frequency.sv
sim/augmented_term_frequency_tb.sv
